### design/triangle_column_span_defines.svh
// Assertion helpers used by the file that checks this block.
`ifndef TRIANGLE_COLUMN_SPAN_DEFINES_SVH
`define TRIANGLE_COLUMN_SPAN_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### design/tcs_pkg.sv
package tcs_pkg;

  // Vertex coordinate width and the width of an edge's x extent.
  localparam int VTX_W = 16;
  localparam int DEN_W = VTX_W + 1;
  localparam int COLOR_W = 24;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_A_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B_X = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_B_Y = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C_X = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VERTEX_C_Y = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_FILL_COLOR = 3'd6;

  // Endpoints of one triangle edge, in vertex units.
  typedef struct packed {
    logic signed [VTX_W-1:0] x0;
    logic signed [VTX_W-1:0] y0;
    logic signed [VTX_W-1:0] x1;
    logic signed [VTX_W-1:0] y1;
  } edge_t;

endpackage

### design/tcs_edge.sv
module tcs_edge #(
  parameter int CW = 17,
  parameter int K = 16,
  parameter int WW = 38,
  parameter bit LOWER = 1'b0
) (
  input  logic                             clk_i,
  input  logic [3:0]                       en_i,
  input  tcs_pkg::edge_t                   edge_i,
  input  logic signed [CW-1:0]             xs_i,
  output logic signed [WW-1:0]             num_o,
  output logic [tcs_pkg::DEN_W-1:0]        den_o,
  output logic                             ok_o
);
  import tcs_pkg::*;

  localparam int DW = VTX_W + 1;
  localparam int P0W = VTX_W + DW;
  localparam int P1W = DW + CW;
  localparam int NW = P1W + 1;

  logic signed [DW-1:0]    d1_q, dy1_q;
  logic signed [CW-1:0]    dx1_q;
  logic signed [VTX_W-1:0] y01_q;
  logic                    ok1_q;

  logic signed [P0W-1:0]   p0_q;
  logic signed [P1W-1:0]   p1_q;
  logic [DEN_W-1:0]        den2_q, den3_q;
  logic                    neg2_q, neg3_q, ok2_q, ok3_q;

  logic signed [NW-1:0]    n3_q;
  logic signed [WW-1:0]    xw, nw;

  // Differences of the endpoints and of the column from the first endpoint.
  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      d1_q  <= DW'(edge_i.x1) - DW'(edge_i.x0);
      dy1_q <= DW'(edge_i.y1) - DW'(edge_i.y0);
      dx1_q <= xs_i - CW'(edge_i.x0);
      y01_q <= edge_i.y0;
      ok1_q <= edge_i.x1 != edge_i.x0;
    end
  end

  // Products of the line equation; the extent is made positive.
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      p0_q   <= y01_q * d1_q;
      p1_q   <= dy1_q * dx1_q;
      den2_q <= d1_q[DW-1] ? DEN_W'(-d1_q) : DEN_W'(d1_q);
      neg2_q <= d1_q[DW-1] ^ LOWER;
      ok2_q  <= ok1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      n3_q   <= NW'(p0_q) + NW'(p1_q);
      den3_q <= den2_q;
      neg3_q <= neg2_q;
      ok3_q  <= ok2_q;
    end
  end

  // The numerator is offset by den * 2^K so that the quotient is unsigned.
  assign xw = $signed(WW'(den3_q)) <<< K;
  assign nw = WW'(n3_q);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      num_o <= neg3_q ? (xw - nw) : (xw + nw);
      den_o <= den3_q;
      ok_o  <= ok3_q;
    end
  end

endmodule

### design/tcs_div.sv
module tcs_div #(
  parameter int K = 16,
  parameter int WW = 38
) (
  input  logic                        clk_i,
  input  logic [K+1:0]                en_i,
  input  logic signed [WW-1:0]        num_i,
  input  logic [tcs_pkg::DEN_W-1:0]   den_i,
  output logic [K:0]                  quo_o
);
  import tcs_pkg::*;

  localparam int QW = K + 1;
  localparam int RW = K + DEN_W + 1;

  logic [RW-1:0]    r_q   [QW-1:0];
  logic [DEN_W-1:0] d_q   [QW-1:0];
  logic [QW-1:0]    q_q   [QW:0];
  logic             lo_q  [QW:0];
  logic             hi_q  [QW:0];
  logic signed [WW-1:0] lim;

  // Quotients outside the K+1 bit window clamp to its ends.
  assign lim = $signed(WW'(den_i)) <<< QW;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      r_q[0]  <= num_i[RW-1:0];
      d_q[0]  <= den_i;
      q_q[0]  <= '0;
      lo_q[0] <= num_i[WW-1];
      hi_q[0] <= !num_i[WW-1] && (num_i >= lim);
    end
  end

  // One restoring step per stage, most significant quotient bit first.
  for (genvar j = 1; j <= QW; j++) begin : g_step
    localparam int B = QW - j;
    logic [RW-1:0] sub;
    logic          take;

    assign sub  = RW'(d_q[j-1]) << B;
    assign take = r_q[j-1] >= sub;

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        q_q[j]  <= {q_q[j-1][QW-2:0], take};
        lo_q[j] <= lo_q[j-1];
        hi_q[j] <= hi_q[j-1];
      end
    end

    if (j < QW) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (en_i[j]) begin
          r_q[j] <= take ? (r_q[j-1] - sub) : r_q[j-1];
          d_q[j] <= d_q[j-1];
        end
      end
    end
  end

  assign quo_o = lo_q[QW] ? '0 : (hi_q[QW] ? '1 : q_q[QW]);

endmodule

### design/triangle_column_span.sv
// Column span unit for triangle fill. Vertices a, b, c (a leftmost) and the
// fill color are written through the write port; the user must do so only
// while no beat is in flight, as the block itself does not enforce this. Each
// input beat carries a pixel column; one output beat per input gives the rows
// covered in that column, from the ceiling of the lower edge to the floor of
// the upper edge, saturated to the row range, with span_empty set (and both
// rows zero) when the column misses the triangle or the edge there is
// vertical. The unit takes one column per clock while the output is not
// stalled. The pipelined divider spends one stage per quotient bit.
// Stalls on the output back up stage by stage, so empty stages keep
// accepting input while a finished span waits.
`include "triangle_column_span_defines.svh"

module triangle_column_span #(
  parameter int COORD_FRAC_BITS = 4,
  parameter int COORD_INT_BITS = 12
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tcs_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [tcs_pkg::COLOR_W-1:0]          cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic signed [COORD_INT_BITS-1:0]     column_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic signed [COORD_INT_BITS-1:0]     column_out_o,
  output logic signed [COORD_INT_BITS-1:0]     row_low_o,
  output logic signed [COORD_INT_BITS-1:0]     row_high_o,
  output logic                                 span_empty_o,
  output logic [tcs_pkg::COLOR_W-1:0]          color_out_o
);
  import tcs_pkg::*;

  // Scaled column width and the width used for x comparisons.
  localparam int XS_W = COORD_INT_BITS + COORD_FRAC_BITS;
  localparam int CW = ((XS_W > VTX_W) ? XS_W : VTX_W) + 1;
  // Quotients are kept in a window of +-2^K vertex units; this covers every
  // interpolated edge value and every saturated row.
  localparam int K = (XS_W > 16) ? XS_W : 16;
  localparam int QW = K + 1;
  localparam int NW = VTX_W + 1 + CW + 1;
  localparam int WW = ((NW > DEN_W + K + 2) ? NW : DEN_W + K + 2) + 1;
  // Stage 1 selects edges, 2..5 form the numerator, 6..S-1 divide, S is
  // the output register.
  localparam int S = QW + 7;
  localparam int DIV0 = 6;

  localparam logic signed [QW:0] ROW_MAX = (QW+1)'((1 << (COORD_INT_BITS-1)) - 1);
  localparam logic signed [QW:0] ROW_MIN = (QW+1)'(-(1 << (COORD_INT_BITS-1)));

  // Configuration registers.
  logic signed [VTX_W-1:0] ax_q, ay_q, bx_q, by_q, cx_q, cy_q;
  logic [COLOR_W-1:0]      color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ax_q    <= '0;
      ay_q    <= '0;
      bx_q    <= '0;
      by_q    <= '0;
      cx_q    <= '0;
      cy_q    <= '0;
      color_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VERTEX_A_X: ax_q <= cfg_data_i[VTX_W-1:0];
        REG_VERTEX_A_Y: ay_q <= cfg_data_i[VTX_W-1:0];
        REG_VERTEX_B_X: bx_q <= cfg_data_i[VTX_W-1:0];
        REG_VERTEX_B_Y: by_q <= cfg_data_i[VTX_W-1:0];
        REG_VERTEX_C_X: cx_q <= cfg_data_i[VTX_W-1:0];
        REG_VERTEX_C_Y: cy_q <= cfg_data_i[VTX_W-1:0];
        REG_FILL_COLOR: color_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign color_out_o = color_q;

  // Stage valid bits and the backward enable chain: a stage loads when it
  // is empty or when the stage after it moves on.
  logic [S:1]   v_q;
  logic [S+1:1] en;

  assign en[S+1] = out_ready_i;
  for (genvar k = 1; k <= S; k++) begin : g_ctl
    assign en[k] = !v_q[k] || en[k+1];
    if (k == 1) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (en[k]) begin
          v_q[k] <= in_valid_i;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[k] <= 1'b0;
        end else if (en[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign in_ready_o  = en[1];
  assign out_valid_o = v_q[S];

  // Stage 1: pick the lower and upper edge for this column. When b is the
  // lowest vertex the lower edge bends at b; otherwise the upper edge bends
  // at c. The first matching x range wins.
  logic signed [CW-1:0] xs, axw, bxw, cxw;
  logic                 b_low, in_ab, in_bc, in_ac, in_cb, in_tri;
  edge_t                edge_ab, edge_bc, edge_ac, edge_cb, low_sel, up_sel;

  assign xs  = CW'(column_i) <<< COORD_FRAC_BITS;
  assign axw = CW'(ax_q);
  assign bxw = CW'(bx_q);
  assign cxw = CW'(cx_q);

  assign b_low = (by_q < cy_q) && (by_q < ay_q);
  assign in_ab = (xs >= axw) && (xs <= bxw);
  assign in_bc = (xs >= bxw) && (xs <= cxw);
  assign in_ac = (xs >= axw) && (xs <= cxw);
  assign in_cb = (xs >= cxw) && (xs <= bxw);

  assign edge_ab = '{x0: ax_q, y0: ay_q, x1: bx_q, y1: by_q};
  assign edge_bc = '{x0: bx_q, y0: by_q, x1: cx_q, y1: cy_q};
  assign edge_ac = '{x0: ax_q, y0: ay_q, x1: cx_q, y1: cy_q};
  assign edge_cb = '{x0: cx_q, y0: cy_q, x1: bx_q, y1: by_q};

  assign low_sel = (b_low && !in_ab && in_bc) ? edge_bc : edge_ab;
  assign up_sel  = (!b_low && !in_ac && in_cb) ? edge_cb : edge_ac;
  assign in_tri  = b_low ? (in_ab || in_bc) : (in_ac || in_cb);

  edge_t                            low_q, up_q;
  logic signed [CW-1:0]             xs_q;
  logic signed [COORD_INT_BITS-1:0] col_q [S-1:1];
  logic                             ins_q [S-1:1];

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      low_q    <= low_sel;
      up_q     <= up_sel;
      xs_q     <= xs;
      col_q[1] <= column_i;
      ins_q[1] <= in_tri;
    end
  end

  for (genvar k = 2; k <= S-1; k++) begin : g_side
    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        col_q[k] <= col_q[k-1];
        ins_q[k] <= ins_q[k-1];
      end
    end
  end

  // Stages 2 to 5: line numerators. The lower edge is negated so that its
  // ceiling comes out of the same floor division.
  logic signed [WW-1:0] num_l, num_u;
  logic [DEN_W-1:0]     den_l, den_u;
  logic                 ok_l, ok_u;

  tcs_edge #(.CW(CW), .K(K), .WW(WW), .LOWER(1'b1)) u_edge_low (
    .clk_i  (clk_i),
    .en_i   (en[5:2]),
    .edge_i (low_q),
    .xs_i   (xs_q),
    .num_o  (num_l),
    .den_o  (den_l),
    .ok_o   (ok_l)
  );

  tcs_edge #(.CW(CW), .K(K), .WW(WW), .LOWER(1'b0)) u_edge_up (
    .clk_i  (clk_i),
    .en_i   (en[5:2]),
    .edge_i (up_q),
    .xs_i   (xs_q),
    .num_o  (num_u),
    .den_o  (den_u),
    .ok_o   (ok_u)
  );

  logic okl_q [S-1:DIV0];
  logic oku_q [S-1:DIV0];

  for (genvar k = DIV0; k <= S-1; k++) begin : g_ok
    if (k == DIV0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          okl_q[k] <= ok_l;
          oku_q[k] <= ok_u;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en[k]) begin
          okl_q[k] <= okl_q[k-1];
          oku_q[k] <= oku_q[k-1];
        end
      end
    end
  end

  // Stages 6 to S-1: two floor dividers, one quotient bit per stage.
  logic [QW-1:0] quo_l, quo_u;

  tcs_div #(.K(K), .WW(WW)) u_div_low (
    .clk_i (clk_i),
    .en_i  (en[S-1:DIV0]),
    .num_i (num_l),
    .den_i (den_l),
    .quo_o (quo_l)
  );

  tcs_div #(.K(K), .WW(WW)) u_div_up (
    .clk_i (clk_i),
    .en_i  (en[S-1:DIV0]),
    .num_i (num_u),
    .den_i (den_u),
    .quo_o (quo_u)
  );

  // Output stage: remove the offset, drop the fraction bits, compare the
  // exact rows and saturate.
  logic signed [QW-1:0] ql, qh;
  logic signed [QW:0]   rlo, rhi;
  logic                 filled;

  assign ql = $signed({~quo_l[QW-1], quo_l[QW-2:0]});
  assign qh = $signed({~quo_u[QW-1], quo_u[QW-2:0]});
  assign rlo = -((QW+1)'(ql >>> COORD_FRAC_BITS));
  assign rhi = (QW+1)'(qh >>> COORD_FRAC_BITS);
  assign filled = ins_q[S-1] && okl_q[S-1] && oku_q[S-1] && (rlo <= rhi);

  function automatic logic signed [COORD_INT_BITS-1:0] sat_row(
    input logic signed [QW:0] v
  );
    logic signed [QW:0] c;
    c = (v > ROW_MAX) ? ROW_MAX : ((v < ROW_MIN) ? ROW_MIN : v);
    return c[COORD_INT_BITS-1:0];
  endfunction

  always_ff @(posedge clk_i) begin
    if (en[S]) begin
      column_out_o <= col_q[S-1];
      row_low_o    <= filled ? sat_row(rlo) : '0;
      row_high_o   <= filled ? sat_row(rhi) : '0;
      span_empty_o <= !filled;
    end
  end

  // An empty span always reports zero rows.
  `TCS_ASSERT_NOW(a_empty_zero, out_valid_o && span_empty_o,
      row_low_o == '0 && row_high_o == '0, "empty span with nonzero rows")
  // A covered span never runs backwards.
  `TCS_ASSERT_NOW(a_span_order, out_valid_o && !span_empty_o,
      $signed(row_low_o) <= $signed(row_high_o), "span with low row above high row")
  // When the output can move, every stage can move, so input is taken.
  `TCS_ASSERT_NOW(a_ready_chain, !out_valid_o || out_ready_i,
      in_ready_o, "input blocked while the output stage is free")
  // A taken beat with nothing behind it leaves the output empty.
  `TCS_ASSERT_NEXT(a_drain, out_valid_o && out_ready_i && !v_q[S-1],
      !out_valid_o, "output beat repeated")

endmodule
